// ----- rtl/tsfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfs_pkg
// Shared types and constants for the touch sample filter scan core.
// ----------------------------------------------------------------------------
package tsfs_pkg;

  localparam int SAMPLES_PER_READ = 5;
  localparam int SCAN_GROUPS      = 4;
  localparam int GRP_W            = 2;
  localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(SCAN_GROUPS - 1);

  localparam int SAMPLE_W = 13;
  localparam int POS_W    = $clog2(SAMPLES_PER_READ);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLES_PER_READ - 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(SAMPLES_PER_READ);

  localparam int TRIM_DIV    = SAMPLES_PER_READ - 2;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / TRIM_DIV);
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int SCALE_W    = 20;
  localparam int OFFSET_W   = 16;
  localparam int WINDOW_W   = 10;
  localparam int COORD_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int PX_W       = SCALE_W + SAMPLE_W + 1;
  localparam int V_W        = PX_W + 1;

  localparam logic [COORD_W-1:0]  COORD_MAX  = '1;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(65536);
  localparam logic [WINDOW_W-1:0] WINDOW_RST = WINDOW_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_SCALE  = 3'd0,
    REG_Y_SCALE  = 3'd1,
    REG_X_OFFSET = 3'd2,
    REG_Y_OFFSET = 3'd3,
    REG_WINDOW   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_PENUP,
    OP_SAMPLE
  } op_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_TRIM,
    B_MUL1,
    B_MUL2,
    B_FIX,
    B_AGREE,
    B_MULXY,
    B_SAT,
    B_EMIT
  } bstate_t;

  typedef struct packed {
    op_t                 op;
    logic                ack;
    logic                raw;
    logic                first;
    logic                last;
    logic [GRP_W-1:0]    grp;
    logic [SAMPLE_W-1:0] sample;
  } qent_t;

  typedef struct packed {
    logic [SCALE_W-1:0]  x_scale;
    logic [SCALE_W-1:0]  y_scale;
    logic [OFFSET_W-1:0] x_offset;
    logic [OFFSET_W-1:0] y_offset;
    logic [WINDOW_W-1:0] window;
  } cfg_t;

  typedef struct packed {
    logic               touching;
    logic               press_captured;
    logic [COORD_W-1:0] x_position;
    logic [COORD_W-1:0] y_position;
    logic [COORD_W-1:0] press_x;
    logic [COORD_W-1:0] press_y;
    logic               reading_ok;
  } res_t;

endpackage

// ----- rtl/tsfs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfs_front
// Accepts input beats, tracks scan position and tags each beat for the back.
// ----------------------------------------------------------------------------
module tsfs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           pen_down,
  input  logic [15:0]                    sample_word,
  input  logic                           raw_mode,
  input  logic                           ack_press,
  input  logic                           q_full,
  output logic                           q_push,
  output tsfs_pkg::qent_t                q_ent
);
  import tsfs_pkg::*;

  logic             active;
  logic [POS_W-1:0] pos;
  logic [GRP_W-1:0] grp;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_ent.ack    = ack_press;
    q_ent.raw    = raw_mode;
    q_ent.first  = (pos == '0);
    q_ent.last   = (pos == POS_LAST);
    q_ent.grp    = grp;
    q_ent.sample = sample_word[15:3];
    if (active) begin
      q_ent.op = OP_SAMPLE;
    end else if (pen_down) begin
      q_ent.op = OP_START;
    end else begin
      q_ent.op = OP_PENUP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= '0;
      grp    <= '0;
    end else if (q_push) begin
      if (!active) begin
        if (pen_down) begin
          active <= 1'b1;
          pos    <= '0;
          grp    <= '0;
        end
      end else if (pos == POS_LAST) begin
        pos <= '0;
        if (grp == GRP_LAST) begin
          active <= 1'b0;
        end else begin
          grp <= grp + 1'b1;
        end
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/tsfs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfs_queue
// Short FIFO of tagged beats between front and back.
// ----------------------------------------------------------------------------
module tsfs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tsfs_pkg::qent_t wr_ent,
  output logic            full,
  input  logic            pop,
  output tsfs_pkg::qent_t rd_ent,
  output logic            empty
);
  import tsfs_pkg::*;

  qent_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full   = (count == QCNT_W'(QDEPTH));
  assign empty  = (count == '0);
  assign rd_ent = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/tsfs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfs_back
// Trimmed mean, agreement check, calibration and press tracking.
// ----------------------------------------------------------------------------
module tsfs_back (
  input  logic            clk,
  input  logic            rst,
  input  tsfs_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  tsfs_pkg::qent_t q_ent,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output tsfs_pkg::res_t  res
);
  import tsfs_pkg::*;

  bstate_t             state;
  bstate_t             state_next;
  logic                load;

  logic [1:0]          flags;
  logic [1:0]          flags_acked;
  logic [COORD_W-1:0]  cur_x;
  logic [COORD_W-1:0]  cur_y;
  logic [COORD_W-1:0]  fp_x;
  logic [COORD_W-1:0]  fp_y;

  logic [SUM_W-1:0]    acc_sum;
  logic [SAMPLE_W-1:0] acc_min;
  logic [SAMPLE_W-1:0] acc_max;
  logic [GRP_W-1:0]    grp;
  logic                raw_l;
  logic [SUM_W-1:0]    trim;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    q0;
  logic [SUM_W-1:0]    rem;
  logic [SUM_W-1:0]    mean_full;
  logic [SAMPLE_W-1:0] mean;

  logic [SAMPLE_W-1:0] p1x;
  logic [SAMPLE_W-1:0] p1y;
  logic [SAMPLE_W-1:0] p2x;
  logic [SAMPLE_W-1:0] p2y;
  logic [SAMPLE_W-1:0] dx;
  logic [SAMPLE_W-1:0] dy;
  logic [SAMPLE_W:0]   sx;
  logic [SAMPLE_W:0]   sy;
  logic                ok_r;
  logic [SAMPLE_W-1:0] ax;
  logic [SAMPLE_W-1:0] ay;
  logic signed [PX_W-1:0] px;
  logic signed [PX_W-1:0] py;
  logic signed [V_W-1:0]  vx;
  logic signed [V_W-1:0]  vy;
  logic [COORD_W-1:0]  nx;
  logic [COORD_W-1:0]  ny;

  function automatic logic [COORD_W-1:0] sat_pos(input logic signed [V_W-1:0] v);
    if (v[V_W-1]) begin
      return '0;
    end else if (|v[V_W-2:FRAC_W+COORD_W]) begin
      return COORD_MAX;
    end else begin
      return v[FRAC_W+COORD_W-1:FRAC_W];
    end
  endfunction

  assign q_pop       = (state == B_IDLE) && !q_empty;
  assign load        = (state == B_EMIT) && (!out_valid || out_ready);
  assign flags_acked = {flags[1], flags[0] & ~q_ent.ack};

  assign rem       = trim - SUM_W'(q0 * SUM_W'(TRIM_DIV));
  assign mean_full = (rem >= SUM_W'(TRIM_DIV)) ? q0 + 1'b1 : q0;
  assign mean      = mean_full[SAMPLE_W-1:0];

  assign dx = (p1x > p2x) ? p1x - p2x : p2x - p1x;
  assign dy = (p1y > p2y) ? p1y - p2y : p2y - p1y;
  assign sx = {1'b0, p1x} + {1'b0, p2x};
  assign sy = {1'b0, p1y} + {1'b0, p2y};

  assign vx = {px[PX_W-1], px}
            + {{(V_W-OFFSET_W-FRAC_W){cfg.x_offset[OFFSET_W-1]}}, cfg.x_offset, FRAC_W'(0)};
  assign vy = {py[PX_W-1], py}
            + {{(V_W-OFFSET_W-FRAC_W){cfg.y_offset[OFFSET_W-1]}}, cfg.y_offset, FRAC_W'(0)};
  assign nx = !ok_r ? cur_x : (raw_l ? COORD_W'(ax) : sat_pos(vx));
  assign ny = !ok_r ? cur_y : (raw_l ? COORD_W'(ay) : sat_pos(vy));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_pop) begin
          if (q_ent.op == OP_PENUP) begin
            state_next = B_EMIT;
          end else if (q_ent.op == OP_SAMPLE && q_ent.last) begin
            state_next = B_TRIM;
          end
        end
      end
      B_TRIM:  state_next = B_MUL1;
      B_MUL1:  state_next = B_MUL2;
      B_MUL2:  state_next = B_FIX;
      B_FIX:   state_next = (grp == GRP_LAST) ? B_AGREE : B_IDLE;
      B_AGREE: state_next = B_MULXY;
      B_MULXY: state_next = B_SAT;
      B_SAT:   state_next = B_EMIT;
      B_EMIT: begin
        if (load) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      cur_x <= '0;
      cur_y <= '0;
      fp_x  <= '0;
      fp_y  <= '0;
    end else if (q_pop) begin
      flags <= flags_acked;
      if (q_ent.op == OP_PENUP) begin
        if (flags[1]) begin
          flags <= {1'b0, flags_acked[0]};
        end else begin
          fp_x  <= '0;
          fp_y  <= '0;
          cur_x <= COORD_MAX;
          cur_y <= COORD_MAX;
        end
      end
    end else if (state == B_SAT) begin
      cur_x <= nx;
      cur_y <= ny;
      if (!flags[1]) begin
        flags <= 2'b11;
        fp_x  <= nx;
        fp_y  <= ny;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (q_pop) begin
          if (q_ent.op == OP_PENUP) begin
            ok_r <= 1'b0;
          end
          if (q_ent.op == OP_SAMPLE) begin
            grp   <= q_ent.grp;
            raw_l <= q_ent.raw;
            if (q_ent.first) begin
              acc_sum <= SUM_W'(q_ent.sample);
              acc_min <= q_ent.sample;
              acc_max <= q_ent.sample;
            end else begin
              acc_sum <= acc_sum + SUM_W'(q_ent.sample);
              if (q_ent.sample < acc_min) begin
                acc_min <= q_ent.sample;
              end
              if (q_ent.sample > acc_max) begin
                acc_max <= q_ent.sample;
              end
            end
          end
        end
      end
      B_TRIM: trim <= acc_sum - SUM_W'(acc_min) - SUM_W'(acc_max);
      B_MUL1: prod <= PROD_W'(trim) * PROD_W'(RECIP);
      B_MUL2: q0   <= prod[RECIP_SHIFT +: SUM_W];
      B_FIX: begin
        unique case (grp)
          2'd0:    p1x <= mean;
          2'd1:    p1y <= mean;
          2'd2:    p2x <= mean;
          default: p2y <= mean;
        endcase
      end
      B_AGREE: begin
        ok_r <= (dx < SAMPLE_W'(cfg.window)) && (dy < SAMPLE_W'(cfg.window));
        ax   <= sx[SAMPLE_W:1];
        ay   <= sy[SAMPLE_W:1];
      end
      B_MULXY: begin
        px <= PX_W'($signed(cfg.x_scale)) * $signed({{(PX_W-SAMPLE_W){1'b0}}, ax});
        py <= PX_W'($signed(cfg.y_scale)) * $signed({{(PX_W-SAMPLE_W){1'b0}}, ay});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.touching       <= flags[1];
      res.press_captured <= flags[0];
      res.x_position     <= cur_x;
      res.y_position     <= cur_y;
      res.press_x        <= fp_x;
      res.press_y        <= fp_y;
      res.reading_ok     <= ok_r;
    end
  end

`ifndef SYNTHESIS
  a_ok_implies_touch: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.reading_ok |-> res.touching)
    else $error("good reading reported without pen down");

  a_emit_fills: assert property (@(posedge clk) disable iff (rst)
    state == B_EMIT && !out_valid |=> out_valid)
    else $error("result not loaded into empty output register");

  a_last_group: assert property (@(posedge clk) disable iff (rst)
    state == B_FIX && grp == GRP_LAST |=> state == B_AGREE)
    else $error("last group did not go to agreement check");

  a_pen_set: assert property (@(posedge clk) disable iff (rst)
    state == B_SAT |=> flags[1])
    else $error("pen-down flag clear after pen-down scan");
`endif

endmodule

// ----- rtl/touch_sample_filter_scan_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_filter_scan_core
// Resistive touch scan filter: one beat per converter word, one result per
// scan. A beat with no scan active starts one: pen up gives a result at once,
// pen down is followed by 4 x 5 sample beats (X, Y, X, Y groups). Each group
// is trimmed (min and max dropped) and averaged, the X and Y pairs must agree
// within the window, then the averages are scaled, offset and clamped unless
// raw mode is set. The front takes a beat per cycle while its 4-entry queue
// has room; the back drains one sample beat per cycle except while busy with
// the trim, reciprocal multiply and correction states at the end of each
// group, or the agreement, calibration multiply, clamp and result load states
// at scan end. A pen-up scan goes straight to result load. Configuration
// writes are taken every cycle and must be made only while the block is idle.
// ----------------------------------------------------------------------------
module touch_sample_filter_scan_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                pen_down,
  input  logic [15:0]                         sample_word,
  input  logic                                raw_mode,
  input  logic                                ack_press,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                touching,
  output logic                                press_captured,
  output logic [tsfs_pkg::COORD_W-1:0]        x_position,
  output logic [tsfs_pkg::COORD_W-1:0]        y_position,
  output logic [tsfs_pkg::COORD_W-1:0]        press_x,
  output logic [tsfs_pkg::COORD_W-1:0]        press_y,
  output logic                                reading_ok
);
  import tsfs_pkg::*;

  cfg_t  cfg;
  qent_t push_ent;
  qent_t pop_ent;
  res_t  res;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_scale  <= SCALE_RST;
      cfg.y_scale  <= SCALE_RST;
      cfg.x_offset <= '0;
      cfg.y_offset <= '0;
      cfg.window   <= WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_X_SCALE:  cfg.x_scale  <= cfg_data[SCALE_W-1:0];
        REG_Y_SCALE:  cfg.y_scale  <= cfg_data[SCALE_W-1:0];
        REG_X_OFFSET: cfg.x_offset <= cfg_data[OFFSET_W-1:0];
        REG_Y_OFFSET: cfg.y_offset <= cfg_data[OFFSET_W-1:0];
        REG_WINDOW:   cfg.window   <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  tsfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pen_down    (pen_down),
    .sample_word (sample_word),
    .raw_mode    (raw_mode),
    .ack_press   (ack_press),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ent       (push_ent)
  );

  tsfs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_ent (push_ent),
    .full   (q_full),
    .pop    (q_pop),
    .rd_ent (pop_ent),
    .empty  (q_empty)
  );

  tsfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_ent     (pop_ent),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign touching       = res.touching;
  assign press_captured = res.press_captured;
  assign x_position     = res.x_position;
  assign y_position     = res.y_position;
  assign press_x        = res.press_x;
  assign press_y        = res.press_y;
  assign reading_ok     = res.reading_ok;

endmodule

// ----- tb/tb_touch_sample_filter_scan_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_sample_filter_scan_core
// Self-checking bench for the touch scan filter. It starts with a short table
// of pen-up and pen-down scans at the field extremes. Random scans follow
// across several calibration settings. A software copy of the filter
// predicts one result per finished scan. The bench compares each output beat
// field by field. Both sides insert random gaps, and the output side holds
// off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_touch_sample_filter_scan_core;
  import tsfs_pkg::*;

  localparam int SPR           = SAMPLES_PER_READ;
  localparam int RANDOM_BEATS  = 2000;
  localparam int PHASES        = 10;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_EVERY    = 60;

  localparam res_t NO_RES     = '0;
  localparam res_t UP_FRESH   = '{1'b0, 1'b0, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 1'b0};
  localparam res_t FIRST_RAW  = '{1'b1, 1'b1, 16'h1fff, 16'h0000, 16'h1fff, 16'h0000, 1'b1};
  localparam res_t UP_RELEASE = '{1'b0, 1'b0, 16'h1fff, 16'h0000, 16'h1fff, 16'h0000, 1'b0};

  typedef struct {
    logic        pen;
    logic [15:0] word;
    logic        raw;
    logic        ack;
    int          reps;
    bit          typed;
    res_t        want;
  } dir_row_t;

  // pen-up from reset, then a full-scale X / zero Y press in raw mode, then release
  dir_row_t dir_rows [9] = '{
    '{1'b0, 16'h0000, 1'b0, 1'b0, 1,       1'b1, UP_FRESH},
    '{1'b0, 16'hffff, 1'b1, 1'b1, 1,       1'b1, UP_FRESH},
    '{1'b1, 16'h0000, 1'b0, 1'b0, 1,       1'b0, NO_RES},
    '{1'b0, 16'hffff, 1'b0, 1'b0, SPR,     1'b0, NO_RES},
    '{1'b1, 16'h0000, 1'b1, 1'b1, SPR,     1'b0, NO_RES},
    '{1'b0, 16'hffff, 1'b0, 1'b0, SPR,     1'b0, NO_RES},
    '{1'b0, 16'h0000, 1'b0, 1'b0, SPR - 1, 1'b0, NO_RES},
    '{1'b0, 16'h0000, 1'b1, 1'b0, 1,       1'b1, FIRST_RAW},
    '{1'b0, 16'h0000, 1'b0, 1'b1, 1,       1'b1, UP_RELEASE}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  pen_down;
  logic [15:0]           sample_word;
  logic                  raw_mode;
  logic                  ack_press;
  logic                  out_valid;
  logic                  out_ready;
  logic                  touching;
  logic                  press_captured;
  logic [COORD_W-1:0]    x_position;
  logic [COORD_W-1:0]    y_position;
  logic [COORD_W-1:0]    press_x;
  logic [COORD_W-1:0]    press_y;
  logic                  reading_ok;

  // filter model state
  logic [SCALE_W-1:0]  gain_x, gain_y;
  logic [OFFSET_W-1:0] shift_x, shift_y;
  logic [WINDOW_W-1:0] agree_win;
  logic                pen_flag, press_flag;
  logic [COORD_W-1:0]  pos_x, pos_y, first_x, first_y;
  logic [SAMPLE_W-1:0] group_buf [SPR];
  int                  beat_no;
  logic [SAMPLE_W-1:0] x_pass1, y_pass1, x_pass2;

  res_t expected_q [$];
  int   beats_sent;
  int   results_seen;
  int   fail_count;
  bit   steady;

  touch_sample_filter_scan_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pen_down       (pen_down),
    .sample_word    (sample_word),
    .raw_mode       (raw_mode),
    .ack_press      (ack_press),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .touching       (touching),
    .press_captured (press_captured),
    .x_position     (x_position),
    .y_position     (y_position),
    .press_x        (press_x),
    .press_y        (press_y),
    .reading_ok     (reading_ok)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic string res_text(res_t r);
    return $sformatf("touch=%0b press=%0b x=%h y=%h px=%h py=%h ok=%0b", r.touching,
                     r.press_captured, r.x_position, r.y_position, r.press_x, r.press_y,
                     r.reading_ok);
  endfunction

  function automatic logic [SAMPLE_W-1:0] trimmed_avg();
    logic [SAMPLE_W-1:0] s [SPR];
    logic [SAMPLE_W-1:0] t;
    int unsigned         acc;
    s = group_buf;
    acc = 0;
    for (int i = 0; i < SPR - 1; i++) begin
      for (int j = i + 1; j < SPR; j++) begin
        if (s[i] > s[j]) begin
          t = s[i];
          s[i] = s[j];
          s[j] = t;
        end
      end
    end
    for (int i = 1; i < SPR - 1; i++) acc += s[i];
    return SAMPLE_W'(acc / (SPR - 2));
  endfunction

  function automatic bit agrees(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return d < agree_win;
  endfunction

  function automatic logic [COORD_W-1:0] calibrate(logic [SAMPLE_W-1:0] avg,
                                                   logic [SCALE_W-1:0] g,
                                                   logic [OFFSET_W-1:0] o);
    longint v;
    v = longint'($signed(g)) * longint'(avg) + longint'($signed(o)) * 65536;
    if (v < 0) return '0;
    v = v >>> FRAC_W;
    return (v > 65535) ? COORD_MAX : v[COORD_W-1:0];
  endfunction

  // advance the model by one input beat; returns 1 when a scan finished
  function automatic bit predict_beat(input logic pen, input logic [15:0] word,
                                      input logic raw, input logic ack, output res_t r);
    int                  idx;
    int                  grp;
    int                  slot;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] ax, ay;
    logic                ok;
    r = '0;
    ok = 1'b0;
    if (ack) press_flag = 1'b0;
    if (beat_no == 0) begin
      if (pen) begin
        beat_no = 1;
        return 1'b0;
      end
      if (pen_flag) begin
        pen_flag = 1'b0;
      end else begin
        first_x = '0;
        first_y = '0;
        pos_x = COORD_MAX;
        pos_y = COORD_MAX;
      end
    end else begin
      idx = beat_no - 1;
      grp = idx / SPR;
      slot = idx % SPR;
      group_buf[slot] = word[15:3];
      beat_no++;
      if (slot != SPR - 1) return 1'b0;
      mean = trimmed_avg();
      if (grp == 0) begin
        x_pass1 = mean;
        return 1'b0;
      end
      if (grp == 1) begin
        y_pass1 = mean;
        return 1'b0;
      end
      if (grp == 2) begin
        x_pass2 = mean;
        return 1'b0;
      end
      beat_no = 0;
      if (agrees(x_pass1, x_pass2) && agrees(y_pass1, mean)) begin
        ax = SAMPLE_W'(({1'b0, x_pass1} + {1'b0, x_pass2}) >> 1);
        ay = SAMPLE_W'(({1'b0, y_pass1} + {1'b0, mean}) >> 1);
        ok = 1'b1;
        if (raw) begin
          pos_x = COORD_W'(ax);
          pos_y = COORD_W'(ay);
        end else begin
          pos_x = calibrate(ax, gain_x, shift_x);
          pos_y = calibrate(ay, gain_y, shift_y);
        end
      end
      if (!pen_flag) begin
        pen_flag = 1'b1;
        press_flag = 1'b1;
        first_x = pos_x;
        first_y = pos_y;
      end
    end
    r.touching = pen_flag;
    r.press_captured = press_flag;
    r.x_position = pos_x;
    r.y_position = pos_y;
    r.press_x = first_x;
    r.press_y = first_y;
    r.reading_ok = ok;
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] jitter(logic [SAMPLE_W-1:0] b, int w);
    int v;
    v = int'(b) + int'($urandom_range(0, 2 * w)) - w;
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_base();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // call at a rising edge; returns at the edge that accepted the beat
  task automatic send_beat(input logic pen, input logic [15:0] word, input logic raw,
                           input logic ack, input bit typed, input res_t want);
    int   gap;
    res_t r;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pen_down    <= pen;
    sample_word <= word;
    raw_mode    <= raw;
    ack_press   <= ack;
    do @(posedge clk); while (!in_ready);
    if (predict_beat(pen, word, raw, ack, r)) expected_q.push_back(typed ? want : r);
    beats_sent++;
  endtask

  task automatic random_scan();
    logic [SAMPLE_W-1:0] base [SCAN_GROUPS];
    logic [SAMPLE_W-1:0] s;
    logic [15:0]         word;
    int                  spread;
    if ($urandom_range(0, 4) == 0) begin
      send_beat(1'b0, 16'($urandom), 1'($urandom), $urandom_range(0, 3) == 0, 1'b0, NO_RES);
      return;
    end
    send_beat(1'b1, 16'($urandom), 1'($urandom), $urandom_range(0, 3) == 0, 1'b0, NO_RES);
    base[0] = pick_base();
    base[1] = pick_base();
    base[2] = ($urandom_range(0, 4) == 0) ? pick_base() : jitter(base[0], agree_win + 2);
    base[3] = ($urandom_range(0, 4) == 0) ? pick_base() : jitter(base[1], agree_win + 2);
    spread = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 400);
    for (int g = 0; g < SCAN_GROUPS; g++) begin
      for (int k = 0; k < SPR; k++) begin
        s = jitter(base[g], spread);
        word = ($urandom_range(0, 9) == 0) ? 16'($urandom) : {s, 3'($urandom)};
        send_beat(1'($urandom), word, 1'($urandom), $urandom_range(0, 3) == 0, 1'b0,
                  NO_RES);
      end
    end
  endtask

  task automatic settle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes every register in index order; upper offset and window data bits carry junk
  task automatic write_config(input logic [SCALE_W-1:0] xs, input logic [SCALE_W-1:0] ys,
                              input logic [OFFSET_W-1:0] xo, input logic [OFFSET_W-1:0] yo,
                              input logic [WINDOW_W-1:0] win);
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] val;
    idx = REG_X_SCALE;
    repeat (5) begin
      case (idx)
        REG_X_SCALE:  val = xs;
        REG_Y_SCALE:  val = ys;
        REG_X_OFFSET: val = {4'($urandom), xo};
        REG_Y_OFFSET: val = {4'($urandom), yo};
        default:      val = {10'($urandom), win};
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        REG_X_SCALE:  gain_x = val[SCALE_W-1:0];
        REG_Y_SCALE:  gain_y = val[SCALE_W-1:0];
        REG_X_OFFSET: shift_x = val[OFFSET_W-1:0];
        REG_Y_OFFSET: shift_y = val[OFFSET_W-1:0];
        default:      agree_win = val[WINDOW_W-1:0];
      endcase
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls plus a long hold every HOLD_EVERY results
  initial begin
    int   stall_left;
    int   next_hold;
    res_t got;
    res_t want;
    bit   bad;
    stall_left = 0;
    next_hold = 20;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = '{touching, press_captured, x_position, y_position, press_x, press_y,
                reading_ok};
        results_seen++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d with nothing expected: %s", results_seen, res_text(got));
        end else begin
          want = expected_q.pop_front();
          bad = (got.touching !== want.touching) ||
                (got.press_captured !== want.press_captured) ||
                (got.x_position !== want.x_position) ||
                (got.y_position !== want.y_position) ||
                (got.press_x !== want.press_x) ||
                (got.press_y !== want.press_y) ||
                (got.reading_ok !== want.reading_ok);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d mismatch: expected %s, got %s", results_seen,
                       res_text(want), res_text(got));
          end
        end
      end
      if (stall_left == 0 && results_seen >= next_hold) begin
        next_hold += HOLD_EVERY;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int phase_end;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = REG_X_SCALE;
    cfg_data    = '0;
    in_valid    = 1'b0;
    pen_down    = 1'b0;
    sample_word = '0;
    raw_mode    = 1'b0;
    ack_press   = 1'b0;
    steady      = 1'b0;
    beats_sent   = 0;
    results_seen = 0;
    fail_count   = 0;
    gain_x    = SCALE_RST;
    gain_y    = SCALE_RST;
    shift_x   = '0;
    shift_y   = '0;
    agree_win = WINDOW_RST;
    pen_flag   = 1'b0;
    press_flag = 1'b0;
    pos_x   = '0;
    pos_y   = '0;
    first_x = '0;
    first_y = '0;
    foreach (group_buf[i]) group_buf[i] = '0;
    beat_no = 0;
    x_pass1 = '0;
    y_pass1 = '0;
    x_pass2 = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps)
        send_beat(dir_rows[i].pen, dir_rows[i].word, dir_rows[i].raw, dir_rows[i].ack,
                  dir_rows[i].typed, dir_rows[i].want);
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      steady = (ph % 4 == 1);
      case (ph)
        0: write_config(SCALE_RST, SCALE_RST, 16'h0000, 16'h0000, WINDOW_RST);
        1: write_config(20'h7ffff, 20'h7ffff, 16'h7fff, 16'h7fff, 10'h3ff);
        2: write_config(20'h80000, 20'h80000, 16'h8000, 16'h8000, 10'd1);
        3: write_config(20'($urandom), 20'($urandom), 16'($urandom), 16'($urandom), 10'd0);
        4: write_config(20'hf0000, 20'hf8000, 16'd8191, 16'd4095, 10'd200);
        5: write_config(20'h10000, 20'h0c000, 16'hff9c, 16'd200, 10'h3ff);
        default: write_config(20'($urandom), 20'($urandom), 16'($urandom), 16'($urandom),
                              10'($urandom_range(0, 300)));
      endcase
      phase_end = beats_sent + RANDOM_BEATS / PHASES;
      while (beats_sent < phase_end) random_scan();
      in_valid <= 1'b0;
    end

    settle();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
